[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block's checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/cmcdf_pkg.sv]
// ---------------------------------------------------------------------------
// cmcdf_pkg
// Types and constants shared by the mid-rank CDF engine.
// ---------------------------------------------------------------------------
`default_nettype none

package cmcdf_pkg;

    localparam int MAX_SAMPLES_DEF  = 64;
    localparam int MAX_CLUSTERS_DEF = 16;

    localparam int MODE_W      = 2;
    localparam int VALUE_W     = 32;
    localparam int CLUSTER_W   = 5;
    localparam int KIND_W      = 2;
    localparam int STAT_W      = 21;
    localparam int FRAC_W      = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_IDX_W   = 1;

    localparam logic [STAT_W-1:0]    STAT_MAX         = '1;
    localparam logic [CLUSTER_W-1:0] CLUSTERS_RST     = CLUSTER_W'(16);

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [KIND_W-1:0] KIND_PROP  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TOTAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMB  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_KIND     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTERS = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
        logic [CLUSTER_W-1:0]      cluster;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] statistic;
        logic              no_data;
        logic              overflowed;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_QUERY,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
        logic [CLUSTER_W-1:0]      cluster;
    } qentry_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [CLUSTER_W-1:0] clusters;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SUM_SEL,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

[rtl/core/cmcdf_ram.sv]
// ---------------------------------------------------------------------------
// cmcdf_ram
// Simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module cmcdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/cmcdf_div.sv]
// ---------------------------------------------------------------------------
// cmcdf_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module cmcdf_div #(
    parameter int NUM_W = 24,
    parameter int DVS_W = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DVS_W-1:0] dvs,
    output logic                  done,
    output logic      [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_diff;
    logic             ge;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[NUM_W-1]};
        ge        = rem_sh >= {1'b0, dvs_reg};
        rem_diff  = rem_sh - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = num;
            rem_next  = '0;
            dvs_next  = dvs;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], ge};
            rem_next = ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

[rtl/core/cmcdf_front.sv]
// ---------------------------------------------------------------------------
// cmcdf_front
// Input decode and short request queue ahead of the execution unit.
// ---------------------------------------------------------------------------
`default_nettype none

module cmcdf_front #(
    parameter int MAX_CLUSTERS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire cmcdf_pkg::in_item_t in_data,
    output logic                     q_valid,
    output cmcdf_pkg::qentry_t       q_entry,
    input  wire logic                q_pop
);

    import cmcdf_pkg::*;

    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int EW  = ($clog2(MAX_CLUSTERS + 1) > CLUSTER_W) ?
                         $clog2(MAX_CLUSTERS + 1) : CLUSTER_W;

    qentry_t        slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]  fill_reg, fill_next;
    qentry_t        entry;
    logic           keep;
    logic           push;
    logic           pop;

    // Decode: bad-cluster loads and the unused mode do nothing, so they
    // are absorbed here and never reach the queue.
    always_comb
    begin
        entry.op      = OP_QUERY;
        entry.value   = in_data.value;
        entry.cluster = in_data.cluster;
        keep          = 1'b0;
        unique case (in_data.mode)
            MODE_LOAD:
            begin
                entry.op = OP_LOAD;
                keep     = (in_data.cluster != '0) &&
                           (EW'(in_data.cluster) <= EW'(MAX_CLUSTERS));
            end
            MODE_QUERY:
            begin
                entry.op = OP_QUERY;
                keep     = 1'b1;
            end
            MODE_CLEAR:
            begin
                entry.op = OP_CLEAR;
                keep     = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_stall = (fill_reg == FW'(QUEUE_DEPTH));
    assign pop      = q_pop && (fill_reg != '0);
    assign push     = in_valid && !in_stall && keep;
    assign q_valid  = (fill_reg != '0);
    assign q_entry  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

[rtl/core/cmcdf_back.sv]
// ---------------------------------------------------------------------------
// cmcdf_back
// Execution unit: sample store, per-cluster counts, query sweep and sums.
// ---------------------------------------------------------------------------
`default_nettype none

module cmcdf_back #(
    parameter int MAX_SAMPLES  = 64,
    parameter int MAX_CLUSTERS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmcdf_pkg::cfg_t    cfg,
    input  wire logic               q_valid,
    input  wire cmcdf_pkg::qentry_t q_entry,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output cmcdf_pkg::out_item_t    out_data
);

    import cmcdf_pkg::*;

    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int HW    = $clog2(2 * MAX_SAMPLES + 1);
    localparam int CW    = $clog2(MAX_CLUSTERS);
    localparam int CLW   = $clog2(MAX_CLUSTERS + 1);
    localparam int EW    = (CLW > CLUSTER_W) ? CLW : CLUSTER_W;
    localparam int NUM_W = HW + FRAC_W;
    localparam int DVS_W = CNT_W + 1;
    localparam int RAM_W = VALUE_W + CW;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          size_reg [MAX_CLUSTERS];
    logic [CNT_W-1:0]          size_next [MAX_CLUSTERS];
    logic                      dropped_reg, dropped_next;
    logic [HW-1:0]             half_reg [MAX_CLUSTERS];
    logic [HW-1:0]             half_next [MAX_CLUSTERS];
    logic [HW-1:0]             tot_reg, tot_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [CLW-1:0]            j_reg, j_next;
    logic [STAT_W-1:0]         stat_reg, stat_next;
    logic signed [VALUE_W-1:0] qval_reg, qval_next;
    logic [CLUSTER_W-1:0]      qclus_reg, qclus_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_data_reg, out_data_next;

    logic [CLW-1:0]            m;
    logic [CW-1:0]             load_idx;
    logic [CW-1:0]             j_idx;
    logic [CW-1:0]             hidx;
    logic [CW-1:0]             sidx;
    logic [HW-1:0]             half_rd;
    logic [CNT_W-1:0]          size_rd;
    logic                      ram_we;
    logic [RAM_W-1:0]          ram_rdata;
    logic signed [VALUE_W-1:0] s_val;
    logic [CW-1:0]             s_clu;
    logic                      s_in_use;
    logic [HW-1:0]             inc;
    logic                      excluded;
    logic                      combined;
    logic                      div_start;
    logic [HW-1:0]             div_half;
    logic [CNT_W-1:0]          div_den;
    logic                      div_done;
    logic [NUM_W-1:0]          div_quo;
    logic [STAT_W:0]           stat_sum;

    // clusters_in_use saturates at the store's cluster count
    assign m = (EW'(cfg.clusters) > EW'(MAX_CLUSTERS)) ?
               CLW'(MAX_CLUSTERS) : CLW'(cfg.clusters);

    assign load_idx = CW'(q_entry.cluster - CLUSTER_W'(1));
    assign j_idx    = j_reg[CW-1:0];
    assign s_val    = ram_rdata[RAM_W-1 -: VALUE_W];
    assign s_clu    = ram_rdata[CW-1:0];
    assign hidx     = (state_reg == ST_SCAN_CMP) ? s_clu : j_idx;
    assign sidx     = (state_reg == ST_IDLE) ? load_idx : j_idx;
    assign half_rd  = half_reg[hidx];
    assign size_rd  = size_reg[sidx];
    assign s_in_use = EW'(s_clu) < EW'(m);
    assign inc      = (s_val < qval_reg) ? HW'(2) : ((s_val == qval_reg) ? HW'(1) : '0);
    assign combined = (cfg.kind == KIND_COMB);
    assign excluded = (cfg.kind == KIND_PROP) &&
                      ((EW'(j_reg) + EW'(1)) == EW'(qclus_reg));

    assign ram_we = (state_reg == ST_IDLE) && q_valid && (q_entry.op == OP_LOAD) &&
                    (count_reg != CNT_W'(MAX_SAMPLES));

    cmcdf_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({q_entry.value, load_idx}),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Numerator half*2^16 + den, divisor 2*den: rounds half up
    assign div_half = combined ? tot_reg : half_rd;
    assign div_den  = combined ? count_reg : size_rd;

    cmcdf_div #(
        .NUM_W (NUM_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({div_half, FRAC_W'(div_den)}),
        .dvs   ({div_den, 1'b0}),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign stat_sum = {1'b0, stat_reg} + (STAT_W + 1)'(div_quo[FRAC_W:0]);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        size_next      = size_reg;
        dropped_next   = dropped_reg;
        half_next      = half_reg;
        tot_next       = tot_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        stat_next      = stat_reg;
        qval_next      = qval_reg;
        qclus_next     = qclus_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_entry.op)
                        OP_LOAD:
                        begin
                            if (count_reg == CNT_W'(MAX_SAMPLES))
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                count_next          = count_reg + CNT_W'(1);
                                size_next[load_idx] = size_rd + CNT_W'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next   = '0;
                            dropped_next = 1'b0;
                            for (int k = 0; k < MAX_CLUSTERS; k++)
                            begin
                                size_next[k] = '0;
                            end
                        end
                        OP_QUERY:
                        begin
                            qval_next  = q_entry.value;
                            qclus_next = q_entry.cluster;
                            stat_next  = '0;
                            tot_next   = '0;
                            idx_next   = '0;
                            j_next     = '0;
                            for (int k = 0; k < MAX_CLUSTERS; k++)
                            begin
                                half_next[k] = '0;
                            end
                            state_next = (count_reg == '0) ? ST_DONE : ST_SCAN_RD;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (s_in_use)
                begin
                    half_next[s_clu] = half_rd + inc;
                    tot_next         = tot_reg + inc;
                end
                idx_next   = idx_reg + CNT_W'(1);
                state_next = (idx_reg + CNT_W'(1) == count_reg) ? ST_SUM_SEL : ST_SCAN_RD;
            end
            ST_SUM_SEL:
            begin
                if (combined)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
                else if (j_reg == m)
                begin
                    state_next = ST_DONE;
                end
                else if ((size_rd == '0) || excluded)
                begin
                    j_next = j_reg + CLW'(1);
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    stat_next  = stat_sum[STAT_W] ? STAT_MAX : stat_sum[STAT_W-1:0];
                    j_next     = j_reg + CLW'(1);
                    state_next = combined ? ST_DONE : ST_SUM_SEL;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.statistic  = stat_reg;
                    out_data_next.no_data    = (count_reg == '0);
                    out_data_next.overflowed = dropped_reg;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_CLUSTERS; k++)
            begin
                size_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            size_reg      <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        half_reg     <= half_next;
        tot_reg      <= tot_next;
        idx_reg      <= idx_next;
        j_reg        <= j_next;
        stat_reg     <= stat_next;
        qval_reg     <= qval_next;
        qclus_reg    <= qclus_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

[rtl/core/clustered_midrank_cdf_engine.sv]
// ---------------------------------------------------------------------------
// clustered_midrank_cdf_engine
// Clustered mid-rank empirical CDF engine, Q16 result.
// ---------------------------------------------------------------------------
//
//  Channel  | Signals                         | Flow
//  ---------+---------------------------------+-----------------------------
//  in       | in_valid, in_stall, in_data     | load / query / clear request
//  out      | out_valid, out_stall, out_data  | one result per query
//  cfg      | cfg_we, cfg_index, cfg_data     | register write, no handshake
//
//  Load and clear are each handled within the idle state of the execution unit.
//  Query: a store RAM read and a compare for each stored sample. The combined
//  kind then divides the total once; the others take a select step per counted
//  cluster and a serial-divider pass for each non-empty, non-excluded one.
//  Reset is asynchronous; it empties the store and sets registers to defaults.
//  A two-entry request queue lets loads and clears go on while a result
//  waits on out_stall; in_stall rises only when that queue is full.
//
`default_nettype none

module clustered_midrank_cdf_engine #(
    parameter int MAX_SAMPLES  = cmcdf_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_CLUSTERS = cmcdf_pkg::MAX_CLUSTERS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire cmcdf_pkg::in_item_t                    in_data,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output cmcdf_pkg::out_item_t                        out_data,
    input  wire logic                                   cfg_we,
    input  wire logic [cmcdf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [cmcdf_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import cmcdf_pkg::*;

    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [CLUSTER_W-1:0] clusters_reg, clusters_next;
    cfg_t                 cfg;
    logic                 q_valid;
    qentry_t              q_entry;
    logic                 q_pop;

    // Register file decode; a kind of 3 is treated as total downstream
    always_comb
    begin
        kind_next     = kind_reg;
        clusters_next = clusters_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KIND:     kind_next     = cfg_data[KIND_W-1:0];
                CFG_CLUSTERS: clusters_next = cfg_data[CLUSTER_W-1:0];
                default:      kind_next     = kind_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= KIND_TOTAL;
            clusters_reg <= CLUSTERS_RST;
        end
        else
        begin
            kind_reg     <= kind_next;
            clusters_reg <= clusters_next;
        end
    end

    assign cfg.kind     = kind_reg;
    assign cfg.clusters = clusters_reg;

    // Front end: decode and queue requests
    cmcdf_front #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    // Back end: store, sweep, divide, result register
    cmcdf_back #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[rtl/core/cmcdf_chk.sv]
// ---------------------------------------------------------------------------
// cmcdf_chk
// Port-level checks for the mid-rank CDF engine, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cmcdf_chk (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire cmcdf_pkg::in_item_t               in_data,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire cmcdf_pkg::out_item_t              out_data,
    input wire logic                              cfg_we
);

    import cmcdf_pkg::*;

    // empty store always reports a zero statistic
    `ASSERT_IMPLY(a_nodata_zero, clk, rst_n, out_valid && out_data.no_data, out_data.statistic == '0)

    // a held result stays put
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // a held request stays put
    `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_data))

    // register writes only with both channels quiet
    `ASSERT_IMPLY(a_cfg_quiet, clk, rst_n, cfg_we, !in_valid && !out_valid)

    // no result straight out of reset
    `ASSERT_IMPLY(a_rst_quiet, clk, rst_n, $rose(rst_n), !out_valid)

endmodule

bind clustered_midrank_cdf_engine cmcdf_chk u_chk (.*);

`default_nettype wire
